// ===== design/plcs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_pkg: shared types and constants of the curve scaler
// Table geometry, command and status codes, register indexes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package plcs_pkg;

	localparam int TABLE_DEPTH      = 256;
	localparam int SEARCH_THRESHOLD = 128;
	localparam int ADDR_W           = $clog2(TABLE_DEPTH);
	localparam int CNT_W            = $clog2(TABLE_DEPTH + 1);
	localparam int DIV_STEPS        = 32;
	localparam int STEP_W           = $clog2(DIV_STEPS);

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_FWD    = 2'd1;
	localparam logic [1:0] CMD_INV    = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_ZERO = 2'd2;
	localparam logic [1:0] STAT_SAT  = 2'd3;

	localparam logic REG_MAX_INPUT = 1'b0;
	localparam logic REG_SCALE_EN  = 1'b1;

	localparam logic [14:0] MAX_INPUT_RST = 15'd256;
	localparam logic        SCALE_EN_RST  = 1'b1;

	typedef enum logic [1:0] {ADDR_FIRST, ADDR_LAST, ADDR_NEXT, ADDR_CUR} addr_sel_t;
	typedef enum logic [1:0] {S_HOLD, S_RD, S_PREV, S_INTERP} s_sel_t;
	typedef enum logic [1:0] {OP_NONE, OP_INTERP, OP_SCALE} op_sel_t;

	typedef struct packed {
		logic      in_ready;
		addr_sel_t addr_sel;
		logic      scan_step;
		logic      bs_step;
		s_sel_t    s_sel;
		op_sel_t   op_sel;
		logic      div_init;
		logic      div_step;
		logic      fin_scale;
		logic      set_zero;
		logic      out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic accept;
		logic acc_scale;
		logic acc_fwd;
		logic pass_now;
		logic big;
		logic key_le_rd;
		logic key_ge_rd;
		logic scan_go;
		logic scan_end;
		logic scan_zero;
		logic bs_go;
		logic zero_div;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== design/plcs_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_in_if: request channel
// Command beat with curve point, lookup key and sample.
// ----------------------------------------------------------------------------
interface plcs_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic signed [15:0] point_x;
	logic signed [15:0] point_y;
	logic signed [15:0] key;
	logic signed [15:0] sample;

	modport source (output valid, command, point_x, point_y, key, sample, input ready);
	modport sink   (input valid, command, point_x, point_y, key, sample, output ready);
endinterface

// ===== design/plcs_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_out_if: response channel
// Result beat with status code and pass-through flag.
// ----------------------------------------------------------------------------
interface plcs_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] result;
	logic [1:0]         status;
	logic               passed_through;

	modport source (output valid, result, status, passed_through, input ready);
	modport sink   (input valid, result, status, passed_through, output ready);
endinterface

// ===== design/plcs_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_cfg_if: configuration write channel
// Register index and write data.
// ----------------------------------------------------------------------------
interface plcs_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [14:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/plcs_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_dp: curve scaler datapath
// Point tables, search registers, multiplier, restoring divider,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module plcs_dp import plcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	plcs_in_if.sink    req,
	plcs_cfg_if.sink   cfg,
	plcs_out_if.source rsp,
	input  ctrl_cmd_t  cmd,
	output dp_stat_t   stat
);

	logic signed [15:0] keys_mem [TABLE_DEPTH];
	logic signed [15:0] vals_mem [TABLE_DEPTH];

	logic [CNT_W-1:0]   count_q;
	logic [14:0]        max_q;
	logic               en_q;
	logic [1:0]         cmd_q;
	logic signed [15:0] key_q, sample_q;
	logic signed [15:0] rk_q, rv_q;
	logic [ADDR_W-1:0]  rd_addr;
	logic [CNT_W-1:0]   scan_q, lo_q, hi_q, cur_q;
	logic signed [15:0] prev_k_q, prev_v_q, s_q;
	logic signed [16:0] opa_q, opb_q, dvs_q;
	logic signed [33:0] prod_s1;
	logic [15:0]        rem_q, dv_q;
	logic [31:0]        quo_q;
	logic               neg_q;
	logic [STEP_W-1:0]  step_q;
	logic signed [15:0] res_q;
	logic [1:0]         stat_q;
	logic               pass_q;
	logic               out_valid_q;
	logic signed [15:0] out_res_q;
	logic [1:0]         out_stat_q;
	logic               out_pass_q;

	logic               accept, wr_en, full, pass_now, scale_cmd;
	logic [CNT_W-1:0]   scan_next, new_lo, new_hi;
	logic [33:0]        prod_neg;
	logic [16:0]        dvs_neg, trial;
	logic [31:0]        prod_mag;
	logic signed [32:0] q_pos, q_sgn;
	logic signed [15:0] sat_val;
	logic               sat_hit;
	logic [14:0]        max_eff;

	assign accept    = req.valid && req.ready;
	assign full      = count_q == CNT_W'(TABLE_DEPTH);
	assign wr_en     = accept && req.command == CMD_APPEND && !full;
	assign pass_now  = !en_q || count_q == '0;
	assign scale_cmd = req.command == CMD_FWD || req.command == CMD_INV;
	assign scan_next = scan_q + CNT_W'(1);
	assign req.ready = cmd.in_ready;
	assign cfg.ready = 1'b1;

	always_comb begin
		case (cmd.addr_sel)
			ADDR_FIRST: rd_addr = '0;
			ADDR_LAST:  rd_addr = ADDR_W'(count_q - CNT_W'(1));
			ADDR_NEXT:  rd_addr = scan_next[ADDR_W-1:0];
			ADDR_CUR:   rd_addr = cur_q[ADDR_W-1:0];
			default:    rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			keys_mem[count_q[ADDR_W-1:0]] <= req.point_x;
			vals_mem[count_q[ADDR_W-1:0]] <= req.point_y;
		end
		rk_q <= keys_mem[rd_addr];
		rv_q <= vals_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			max_q   <= MAX_INPUT_RST;
			en_q    <= SCALE_EN_RST;
		end else begin
			if (wr_en)
				count_q <= count_q + CNT_W'(1);
			if (cfg.valid) begin
				case (cfg.index)
					REG_MAX_INPUT: max_q <= cfg.data;
					REG_SCALE_EN:  en_q  <= cfg.data[0];
					default:       ;
				endcase
			end
		end
	end

	// binary search bracket update
	always_comb begin
		new_lo = lo_q;
		new_hi = hi_q;
		if (rk_q < key_q)
			new_lo = cur_q;
		else
			new_hi = cur_q;
	end

	assign max_eff  = (max_q == '0) ? 15'd1 : max_q;
	assign prod_neg = -prod_s1;
	assign prod_mag = prod_s1[33] ? prod_neg[31:0] : prod_s1[31:0];
	assign dvs_neg  = -dvs_q;
	assign trial    = {rem_q, quo_q[31]};
	assign q_pos    = $signed({1'b0, quo_q});
	assign q_sgn    = neg_q ? -q_pos : q_pos;

	always_comb begin
		sat_hit = 1'b0;
		sat_val = q_sgn[15:0];
		if (q_sgn > 33'sd32767) begin
			sat_hit = 1'b1;
			sat_val = 16'sh7fff;
		end else if (q_sgn < -33'sd32768) begin
			sat_hit = 1'b1;
			sat_val = -16'sh8000;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.command;
			key_q    <= req.key;
			sample_q <= req.sample;
			scan_q   <= '0;
			lo_q     <= '0;
			hi_q     <= count_q;
			cur_q    <= count_q >> 1;
			res_q    <= (scale_cmd && pass_now) ? req.sample : 16'sd0;
			stat_q   <= (req.command == CMD_APPEND && full) ? STAT_FULL : STAT_OK;
			pass_q   <= scale_cmd && pass_now;
		end
		if (cmd.scan_step) begin
			prev_k_q <= rk_q;
			prev_v_q <= rv_q;
			scan_q   <= scan_next;
		end
		if (cmd.bs_step) begin
			lo_q  <= new_lo;
			hi_q  <= new_hi;
			cur_q <= new_lo + ((new_hi - new_lo) >> 1);
		end
		case (cmd.s_sel)
			S_RD:     s_q <= rv_q;
			S_PREV:   s_q <= prev_v_q;
			S_INTERP: s_q <= prev_v_q + q_sgn[15:0];
			default:  ;
		endcase
		case (cmd.op_sel)
			OP_INTERP: begin
				opa_q <= $signed({key_q[15], key_q}) - $signed({prev_k_q[15], prev_k_q});
				opb_q <= $signed({rv_q[15], rv_q}) - $signed({prev_v_q[15], prev_v_q});
				dvs_q <= $signed({rk_q[15], rk_q}) - $signed({prev_k_q[15], prev_k_q});
			end
			OP_SCALE: begin
				if (cmd_q == CMD_FWD) begin
					opa_q <= {s_q[15], s_q};
					opb_q <= {sample_q[15], sample_q};
					dvs_q <= {2'b00, max_eff};
				end else begin
					opa_q <= {sample_q[15], sample_q};
					opb_q <= {2'b00, max_q};
					dvs_q <= {s_q[15], s_q};
				end
			end
			default: ;
		endcase
		prod_s1 <= opa_q * opb_q;
		if (cmd.div_init) begin
			quo_q  <= prod_mag;
			rem_q  <= '0;
			dv_q   <= dvs_q[16] ? dvs_neg[15:0] : dvs_q[15:0];
			neg_q  <= prod_s1[33] ^ dvs_q[16];
			step_q <= '0;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, dv_q}) begin
				rem_q <= 16'(trial - {1'b0, dv_q});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[15:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
			step_q <= step_q + STEP_W'(1);
		end
		if (cmd.fin_scale) begin
			res_q  <= sat_val;
			stat_q <= sat_hit ? STAT_SAT : STAT_OK;
		end
		if (cmd.set_zero) begin
			res_q  <= '0;
			stat_q <= STAT_ZERO;
		end
		if (cmd.out_load) begin
			out_res_q  <= res_q;
			out_stat_q <= stat_q;
			out_pass_q <= pass_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.result         = out_res_q;
	assign rsp.status         = out_stat_q;
	assign rsp.passed_through = out_pass_q;

	assign stat.accept    = accept;
	assign stat.acc_scale = scale_cmd;
	assign stat.acc_fwd   = req.command == CMD_FWD;
	assign stat.pass_now  = pass_now;
	assign stat.big       = count_q > CNT_W'(SEARCH_THRESHOLD);
	assign stat.key_le_rd = key_q <= rk_q;
	assign stat.key_ge_rd = key_q >= rk_q;
	assign stat.scan_go   = scan_q < count_q && rk_q <= key_q;
	assign stat.scan_end  = scan_q >= count_q;
	assign stat.scan_zero = scan_q == '0;
	assign stat.bs_go     = (lo_q + CNT_W'(1)) < hi_q && rk_q != key_q;
	assign stat.zero_div  = cmd_q == CMD_INV && s_q == '0;
	assign stat.div_done  = step_q == STEP_W'(DIV_STEPS - 1);
	assign stat.out_free  = !out_valid_q || rsp.ready;

endmodule

// ===== design/plcs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_ctrl: curve scaler sequencer
// Walks clamp checks, linear scan or binary search, then the
// multiply/divide passes, and hands the result to the output register.
// ----------------------------------------------------------------------------
module plcs_ctrl import plcs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	typedef enum logic [11:0] {
		ST_IDLE      = 12'b0000_0000_0001,
		ST_FWD_FIRST = 12'b0000_0000_0010,
		ST_FWD_LAST  = 12'b0000_0000_0100,
		ST_LIN       = 12'b0000_0000_1000,
		ST_BS_RD     = 12'b0000_0001_0000,
		ST_BS_CMP    = 12'b0000_0010_0000,
		ST_SCALE     = 12'b0000_0100_0000,
		ST_MUL       = 12'b0000_1000_0000,
		ST_DIV_INIT  = 12'b0001_0000_0000,
		ST_DIV       = 12'b0010_0000_0000,
		ST_FIN       = 12'b0100_0000_0000,
		ST_OUT       = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   interp_q, interp_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		interp_d = interp_q;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.addr_sel = ADDR_FIRST;
				if (stat.accept) begin
					if (stat.acc_scale && !stat.pass_now) begin
						if (stat.acc_fwd)
							state_d = ST_FWD_FIRST;
						else if (stat.big)
							state_d = ST_BS_RD;
						else
							state_d = ST_LIN;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_FWD_FIRST: begin
				if (stat.key_le_rd) begin
					cmd.s_sel = S_RD;
					state_d   = ST_SCALE;
				end else begin
					cmd.addr_sel = ADDR_LAST;
					state_d      = ST_FWD_LAST;
				end
			end
			ST_FWD_LAST: begin
				cmd.addr_sel = ADDR_FIRST;
				if (stat.key_ge_rd) begin
					cmd.s_sel = S_RD;
					state_d   = ST_SCALE;
				end else if (stat.big) begin
					state_d = ST_BS_RD;
				end else begin
					state_d = ST_LIN;
				end
			end
			ST_LIN: begin
				// prefetch the next entry while comparing this one
				cmd.addr_sel = ADDR_NEXT;
				if (stat.scan_go) begin
					cmd.scan_step = 1'b1;
				end else if (stat.scan_end) begin
					cmd.s_sel = S_PREV;
					state_d   = ST_SCALE;
				end else if (stat.scan_zero) begin
					cmd.s_sel = S_RD;
					state_d   = ST_SCALE;
				end else begin
					cmd.op_sel = OP_INTERP;
					interp_d   = 1'b1;
					state_d    = ST_MUL;
				end
			end
			ST_BS_RD: begin
				cmd.addr_sel = ADDR_CUR;
				state_d      = ST_BS_CMP;
			end
			ST_BS_CMP: begin
				if (stat.bs_go) begin
					cmd.bs_step = 1'b1;
					state_d     = ST_BS_RD;
				end else begin
					cmd.s_sel = S_RD;
					state_d   = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (stat.zero_div) begin
					cmd.set_zero = 1'b1;
					state_d      = ST_OUT;
				end else begin
					cmd.op_sel = OP_SCALE;
					interp_d   = 1'b0;
					state_d    = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_DIV_INIT;
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (interp_q) begin
					cmd.s_sel = S_INTERP;
					state_d   = ST_SCALE;
				end else begin
					cmd.fin_scale = 1'b1;
					state_d       = ST_OUT;
				end
			end
			ST_OUT: begin
				// hold until the output register frees up
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			interp_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			interp_q <= interp_d;
		end
	end

endmodule

// ===== design/piecewise_linear_curve_scaler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_curve_scaler_top: piecewise-linear curve scaler
// Appends curve points and scales samples by a looked-up curve value.
// ----------------------------------------------------------------------------
// Append, pass-through and unused commands go from the accepting edge straight to
// the output load. A scale adds up to 2 clamp reads (forward only), a linear scan
// of the entries or a binary search, an interpolation pass through the multiplier
// and divider, and the scaling multiply and 32-step divide before the output load.
// One item in flight: the next beat is taken in the cycle after the output loads,
// also while a result waits. Reset clears the point count and output valid and
// restores max_input 256, enable 1.
module piecewise_linear_curve_scaler_top import plcs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	plcs_in_if.sink    req,
	plcs_cfg_if.sink   cfg,
	plcs_out_if.source rsp
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	plcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	plcs_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cfg    (cfg),
		.rsp    (rsp),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

// ===== tb/sv/plcs_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plcs_tb_if: channel interfaces of the curve scaler bench
// The request, response and configuration channels are the ones in the design
// folder; this file only groups the types that the bench shares.
// ----------------------------------------------------------------------------
package plcs_tb_pkg;
	import plcs_pkg::*;

	typedef struct {
		logic [1:0]         command;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] key;
		logic signed [15:0] sample;
	} scale_req_t;

	typedef struct {
		logic signed [15:0] result;
		logic [1:0]         status;
		logic               passed_through;
	} scale_rsp_t;
endpackage

// ===== tb/sv/piecewise_linear_curve_scaler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_curve_scaler_top_tb: self-checking bench of the curve scaler
// Builds curve tables of several sizes (interpolated and binary-searched),
// scales samples forward and inverse under several register settings, and
// checks every response beat against a behavioral curve predictor.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_scaler_top_tb;
	import plcs_pkg::*;
	import plcs_tb_pkg::*;

	localparam logic [1:0] CMD_NOP = 2'd3;

	class curve_scoreboard;
		logic signed [15:0] keys[TABLE_DEPTH];
		logic signed [15:0] vals[TABLE_DEPTH];
		int unsigned        npts;
		logic [14:0]        full_scale;
		logic               enable;
		scale_rsp_t         pending[$];
		int                 errors;
		int                 checked;

		function void clear();
			npts = 0;
			full_scale = MAX_INPUT_RST;
			enable = SCALE_EN_RST;
			pending.delete();
		endfunction

		function longint lookup(longint k);
			int unsigned lo, hi, cur, c;
			longint dk, num;
			if (npts > SEARCH_THRESHOLD) begin
				lo = 0;
				hi = npts;
				cur = npts / 2;
				while (lo + 1 < hi && keys[cur] != k) begin
					if (keys[cur] < k) lo = cur; else hi = cur;
					cur = lo + (hi - lo) / 2;
				end
				return vals[cur];
			end
			c = 0;
			while (c < npts && keys[c] <= k) c++;
			if (c >= npts) return vals[npts - 1];
			if (c == 0) return vals[0];
			dk = longint'(keys[c]) - keys[c - 1];
			num = (k - keys[c - 1]) * (longint'(vals[c]) - vals[c - 1]);
			return vals[c - 1] + num / dk;
		endfunction

		function void note_request(scale_req_t r);
			scale_rsp_t e;
			longint s, m, q;
			e.result = 0;
			e.status = STAT_OK;
			e.passed_through = 1'b0;
			if (r.command == CMD_APPEND) begin
				if (npts >= TABLE_DEPTH) e.status = STAT_FULL;
				else begin
					keys[npts] = r.point_x;
					vals[npts] = r.point_y;
					npts++;
				end
			end else if (r.command == CMD_FWD || r.command == CMD_INV) begin
				if (!enable || npts == 0) begin
					e.result = r.sample;
					e.passed_through = 1'b1;
				end else begin
					if (r.command == CMD_FWD) begin
						m = (full_scale != 0) ? longint'(full_scale) : 64'sd1;
						if (r.key <= keys[0]) s = vals[0];
						else if (r.key >= keys[npts - 1]) s = vals[npts - 1];
						else s = lookup(r.key);
						q = s * r.sample / m;
					end else begin
						s = lookup(r.key);
						q = (s == 0) ? 64'sd0 : longint'(r.sample) * longint'(full_scale) / s;
						if (s == 0) e.status = STAT_ZERO;
					end
					if (q > 32767) begin
						q = 32767;
						e.status = STAT_SAT;
					end else if (q < -32768) begin
						q = -32768;
						e.status = STAT_SAT;
					end
					e.result = q[15:0];
				end
			end
			pending.insert(pending.size(), e);
		endfunction

		function void check_response(scale_rsp_t a);
			scale_rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected response result=%0d status=%0d", $time,
					a.result, a.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (a.result !== e.result || a.status !== e.status
				|| a.passed_through !== e.passed_through) begin
				$display("%0t: mismatch expected %0d/%0d/%0b actual %0d/%0d/%0b", $time,
					e.result, e.status, e.passed_through,
					a.result, a.status, a.passed_through);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	plcs_in_if  req();
	plcs_cfg_if cfg();
	plcs_out_if rsp();

	piecewise_linear_curve_scaler_top dut (
		.clk(clk), .arst_n(arst_n), .req(req), .cfg(cfg), .rsp(rsp)
	);

	curve_scoreboard sb = new();
	int burst_left;
	int sent_items;
	int stall_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

	// receiver stall pattern; mode changes now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			case (stall_mode)
				0: rsp.ready <= 1'b1;
				1: rsp.ready <= ($urandom_range(0, 3) != 0);
				default: rsp.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		scale_rsp_t a;
		if (arst_n && rsp.valid && rsp.ready) begin
			a.result = rsp.result;
			a.status = rsp.status;
			a.passed_through = rsp.passed_through;
			sb.check_response(a);
		end
		if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
	end

	// hold valid across a burst; drop it only for the gap before the next one
	task automatic send_item(scale_req_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid   <= 1'b1;
		req.command <= r.command;
		req.point_x <= r.point_x;
		req.point_y <= r.point_y;
		req.key     <= r.key;
		req.sample  <= r.sample;
		do @(posedge clk); while (!req.ready);
		sb.note_request(r);
		sent_items++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic index, logic [14:0] data);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data  <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (index == REG_MAX_INPUT) sb.full_scale = data;
		else sb.enable = data[0];
	endtask

	function automatic scale_req_t make_req(logic [1:0] c, int px, int py, int k, int s);
		scale_req_t r;
		r.command = c;
		r.point_x = px;
		r.point_y = py;
		r.key = k;
		r.sample = s;
		return r;
	endfunction

	function automatic int rnd16();
		return $signed(16'($urandom));
	endfunction

	function automatic logic [1:0] rnd_scale_cmd();
		int p = $urandom_range(0, 19);
		if (p == 0) return CMD_NOP;
		return p < 10 ? CMD_FWD : CMD_INV;
	endfunction

	// fill the table with ascending keys spread over the key range
	task automatic build_curve(int n);
		int step, x;
		step = 65000 / n;
		x = -32700 + $urandom_range(0, step / 2);
		for (int i = 0; i < n; i++) begin
			send_item(make_req(CMD_APPEND, x, ($urandom_range(0, 9) == 0) ? 0 : rnd16(),
				rnd16(), rnd16()));
			x += $urandom_range(1, step);
		end
	endtask

	task automatic scale_burst(int n, int ref_keys);
		int k;
		for (int i = 0; i < n; i++) begin
			if (ref_keys && sb.npts > 0 && $urandom_range(0, 2) == 0)
				k = sb.keys[$urandom_range(0, sb.npts - 1)];
			else k = rnd16();
			send_item(make_req(rnd_scale_cmd(), rnd16(), rnd16(), k, rnd16()));
		end
	endtask

	initial begin
		int rounds;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = CMD_APPEND;
		req.point_x = '0;
		req.point_y = '0;
		req.key = '0;
		req.sample = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_MAX_INPUT;
		cfg.data = '0;
		stall_mode = 0;
		burst_left = 0;
		sent_items = 0;
		sb.clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table pass-through, unused command, small curve
		send_item(make_req(CMD_FWD, 0, 0, 0, 16'sh7fff));
		send_item(make_req(CMD_INV, 0, 0, 0, -32768));
		send_item(make_req(CMD_NOP, 0, 0, 0, 5));
		send_item(make_req(CMD_APPEND, -32768, 0, 0, 0));
		send_item(make_req(CMD_APPEND, 0, 256, 0, 0));
		send_item(make_req(CMD_APPEND, 32767, -32768, 0, 0));
		send_item(make_req(CMD_FWD, 0, 0, -32768, 32767));
		send_item(make_req(CMD_FWD, 0, 0, 32767, 32767));
		send_item(make_req(CMD_FWD, 0, 0, 100, -32768));
		send_item(make_req(CMD_INV, 0, 0, -32768, 1000));
		send_item(make_req(CMD_INV, 0, 0, -100, 32767));
		send_item(make_req(CMD_INV, 0, 0, 32767, -32768));
		write_reg(REG_SCALE_EN, 15'd0);
		send_item(make_req(CMD_FWD, 0, 0, 5, -7));
		write_reg(REG_SCALE_EN, 15'd1);
		write_reg(REG_MAX_INPUT, 15'd0);
		send_item(make_req(CMD_FWD, 0, 0, 5, 300));
		send_item(make_req(CMD_INV, 0, 0, 5, 300));
		write_reg(REG_MAX_INPUT, 15'h7fff);
		send_item(make_req(CMD_FWD, 0, 0, 10, -32768));
		send_item(make_req(CMD_INV, 0, 0, 20, 32767));

		// random phases: the table keeps growing, small curves first
		for (rounds = 0; sent_items < 850; rounds++) begin
			write_reg(REG_MAX_INPUT, (rounds % 5 == 0) ? 15'd1
				: (rounds % 5 == 1) ? 15'h7fff : 15'($urandom_range(1, 32767)));
			write_reg(REG_SCALE_EN, 15'($urandom_range(0, 5) != 0));
			build_curve((rounds % 4 == 3) ? $urandom_range(129, 250) : $urandom_range(1, 40));
			scale_burst(60, 1);
			if ($urandom_range(0, 1)) send_item(make_req(CMD_APPEND, rnd16(), rnd16(), 0, 0));
			scale_burst(20, 0);
		end
		// fill the table completely and push past it
		build_curve(TABLE_DEPTH);
		for (int i = 0; i < 3; i++)
			send_item(make_req(CMD_APPEND, rnd16(), rnd16(), rnd16(), rnd16()));
		scale_burst(30, 1);

		drain();
		$display("covered %0d requests, %0d responses, %0d curve rounds",
			sent_items, sb.checked, rounds);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
design/plcs_pkg.sv
design/plcs_in_if.sv
design/plcs_out_if.sv
design/plcs_cfg_if.sv
design/plcs_dp.sv
design/plcs_ctrl.sv
design/piecewise_linear_curve_scaler_top.sv
tb/sv/plcs_tb_if.sv
tb/sv/piecewise_linear_curve_scaler_top_tb.sv
